>>> design/inverse_trig_angle_unit_assert.svh
// ----------------------------------------------------------------------------
// inverse_trig_angle_unit assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INVERSE_TRIG_ANGLE_UNIT_ASSERT_SVH
`define INVERSE_TRIG_ANGLE_UNIT_ASSERT_SVH

// ANT in one cycle implies CON a fixed number of cycles later
`define ITAU_AST_DLY(LBL, ANT, DLY, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |-> ##(DLY) (CON)) \
    else $error(MSG);

// ANT in one cycle implies CON in the next
`define ITAU_AST_NXT(LBL, ANT, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |=> (CON)) \
    else $error(MSG);

`endif

>>> design/itau_pkg.sv
// ----------------------------------------------------------------------------
// itau_pkg
// Types, stage counts and angle ROMs for the inverse trig angle unit.
// ----------------------------------------------------------------------------
package itau_pkg;

  typedef enum logic [1:0] {
    OP_ASIN  = 2'd0,
    OP_ACOS  = 2'd1,
    OP_ATAN2 = 2'd2,
    OP_NONE  = 2'd3
  } itau_op_t;

  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_PER_STG = 2;
  localparam int SQRT_STG     = SQRT_STEPS / SQRT_PER_STG;
  localparam int DIV_STEPS    = 17;
  localparam int DIV_PER_STG  = 2;
  localparam int DIV_STG      = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int ROM_N        = 256;

  localparam logic [15:0] ANG_QUARTER = 16'h4000;
  localparam logic [15:0] ANG_HALF    = 16'h8000;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;

  // sideband that rides with each word through the pipe
  typedef struct packed {
    itau_op_t    op;
    logic        neg_x;
    logic        neg_y;
    logic        sin_br;
    logic        pre_sat;
    logic        root_zero;
    logic [15:0] lo16;
    logic [31:0] num;
  } itau_side_t;

  typedef logic [15:0] itau_rom_t [0:ROM_N];

  // restoring divide for the table build; the Taylor terms stay below 2^40
  function automatic logic [39:0] itau_udiv40(input logic [39:0] num,
                                              input logic [15:0] den);
    logic [39:0] q;
    logic [16:0] r;
    q = '0;
    r = '0;
    for (int b = 39; b >= 0; b--) begin
      r = {r[15:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(2*pi*t/65536) in Q30, Taylor series; elaboration only
  function automatic logic [63:0] itau_sine_q30(input logic [31:0] t);
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] term;
    longint      sum;
    theta = ({32'd0, t} * 64'd6746518852 + 64'd32768) >> 16;
    th2   = (theta * theta) >> 30;
    term  = theta;
    sum   = longint'(theta);
    for (int n = 1; n <= 12; n++) begin
      term = {24'd0, itau_udiv40(40'((term * th2) >> 30),
                                 16'((2 * n) * (2 * n + 1)))};
      if ((n & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic itau_rom_t itau_build_rom(input logic is_asin);
    itau_rom_t   r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    logic [63:0] tgt;
    for (int i = 0; i < ROM_N; i++) begin
      tgt = 64'(i) << 30;
      lo  = 32'd0;
      hi  = 32'd16384;
      for (int k = 0; k < 16; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 32'd1) >> 1;
          if (itau_sine_q30(mid) * 64'(ROM_N) <= tgt) lo = mid;
          else                                        hi = mid - 32'd1;
        end
      end
      if (is_asin)     r[i] = lo[15:0];
      else if (i == 0) r[i] = 16'd16384;
      else             r[i] = 16'd16383 - lo[15:0];
    end
    r[ROM_N] = r[ROM_N-1];
    return r;
  endfunction

  localparam itau_rom_t ASIN_ROM = itau_build_rom(1'b1);
  localparam itau_rom_t ACOS_ROM = itau_build_rom(1'b0);

endpackage

>>> design/itau_isqrt.sv
// ----------------------------------------------------------------------------
// itau_isqrt
// Pipelined 64-bit integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module itau_isqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [63:0]          in_rad,
  input  itau_pkg::itau_side_t in_side,
  output logic                 out_vld,
  output logic [31:0]          out_root,
  output itau_pkg::itau_side_t out_side
);
  import itau_pkg::*;

  logic        vld_r  [SQRT_STG];
  logic [63:0] rem_r  [SQRT_STG];
  logic [63:0] res_r  [SQRT_STG];
  itau_side_t  side_r [SQRT_STG];

  genvar s;
  for (s = 0; s < SQRT_STG; s++) begin : g_stg
    logic        vld_in;
    logic [63:0] rem_in;
    logic [63:0] res_in;
    itau_side_t  side_in;
    logic [63:0] rem_nxt;
    logic [63:0] res_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_rad;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign res_in  = res_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] trial;
      rem = rem_in;
      res = res_in;
      for (int j = 0; j < SQRT_PER_STG; j++) begin
        bitv  = 64'd1 << (62 - 2 * (s * SQRT_PER_STG + j));
        trial = res + bitv;
        if (rem >= trial) begin
          rem = rem - trial;
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
      end
      rem_nxt = rem;
      res_nxt = res;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      res_r[s]  <= res_nxt;
      side_r[s] <= side_in;
    end
  end

  assign out_vld  = vld_r[SQRT_STG-1];
  assign out_root = res_r[SQRT_STG-1][31:0];
  assign out_side = side_r[SQRT_STG-1];

endmodule

>>> design/itau_div.sv
// ----------------------------------------------------------------------------
// itau_div
// Pipelined restoring divider: floor(num * 65536 / den), 17 quotient bits.
// ----------------------------------------------------------------------------
module itau_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [31:0]          in_num,
  input  logic [31:0]          in_den,
  input  itau_pkg::itau_side_t in_side,
  output logic                 out_vld,
  output logic [16:0]          out_quot,
  output itau_pkg::itau_side_t out_side
);
  import itau_pkg::*;

  logic        vld_r  [DIV_STG];
  logic [31:0] rem_r  [DIV_STG];
  logic [16:0] dl_r   [DIV_STG];
  logic [16:0] quot_r [DIV_STG];
  logic [31:0] den_r  [DIV_STG];
  itau_side_t  side_r [DIV_STG];

  genvar s;
  for (s = 0; s < DIV_STG; s++) begin : g_stg
    logic        vld_in;
    logic [31:0] rem_in;
    logic [16:0] dl_in;
    logic [16:0] quot_in;
    logic [31:0] den_in;
    itau_side_t  side_in;
    logic [31:0] rem_nxt;
    logic [16:0] dl_nxt;
    logic [16:0] quot_nxt;

    if (s == 0) begin : g_first
      // numerator is num << 16; the top 31 bits are already below den
      assign vld_in  = in_vld;
      assign rem_in  = {1'b0, in_num[31:1]};
      assign dl_in   = {in_num[0], 16'd0};
      assign quot_in = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign dl_in   = dl_r[s-1];
      assign quot_in = quot_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [31:0] rem;
      logic [16:0] dl;
      logic [16:0] quot;
      logic [32:0] trial;
      rem  = rem_in;
      dl   = dl_in;
      quot = quot_in;
      for (int j = 0; j < DIV_PER_STG; j++) begin
        if ((s * DIV_PER_STG + j) < DIV_STEPS) begin
          trial = {rem, dl[16]};
          dl    = dl << 1;
          if (trial >= {1'b0, den_in}) begin
            rem  = 32'(trial - {1'b0, den_in});
            quot = {quot[15:0], 1'b1};
          end else begin
            rem  = trial[31:0];
            quot = {quot[15:0], 1'b0};
          end
        end
      end
      rem_nxt  = rem;
      dl_nxt   = dl;
      quot_nxt = quot;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else        vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      dl_r[s]   <= dl_nxt;
      quot_r[s] <= quot_nxt;
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end
  end

  assign out_vld  = vld_r[DIV_STG-1];
  assign out_quot = quot_r[DIV_STG-1];
  assign out_side = side_r[DIV_STG-1];

endmodule

>>> design/inverse_trig_angle_unit.sv
// ----------------------------------------------------------------------------
// inverse_trig_angle_unit
// Pipelined asin / acos / atan2 on Q16.16 operands, angle out in turns/65536.
// ----------------------------------------------------------------------------
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+---------------------
//  in      | in_req_type, in_x_value, in_y_value        | start & !busy
//  out     | out_angle_out                              | out_valid, 1 cycle
//
// One word enters per cycle; busy is always low since nothing ever stalls.
// Each result passes 3 front stages
// (magnitude, squares, sum), 16 square-root stages, 9 divider stages and
// 3 lookup stages. The square-root and divider pipes set most of that depth.
// Synchronous active-low reset clears only the valid bits; words in flight
// are dropped. The receiver cannot stall, so out_valid is a plain strobe.
//
`include "inverse_trig_angle_unit_assert.svh"

module inverse_trig_angle_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  output logic               out_valid,
  output logic [15:0]        out_angle_out
);
  import itau_pkg::*;

  localparam int LAT = 3 + SQRT_STG + DIV_STG + 3;

  // ---- stage 0: magnitudes, branch choice --------------------------------
  logic        acc;
  logic        nx;
  logic        ny;
  logic [31:0] mx;
  logic [31:0] my;
  itau_side_t  side0_nxt;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign nx   = in_x_value[31];
  assign ny   = in_y_value[31];
  assign mx   = nx ? (~in_x_value + 32'd1) : in_x_value;
  assign my   = ny ? (~in_y_value + 32'd1) : in_y_value;

  always_comb begin
    logic y_small;
    y_small             = my < mx;
    side0_nxt.op        = itau_op_t'(in_req_type);
    side0_nxt.neg_x     = nx;
    side0_nxt.neg_y     = ny;
    side0_nxt.pre_sat   = mx >= ONE_Q16;
    side0_nxt.root_zero = 1'b0;
    side0_nxt.lo16      = mx[15:0];
    // atan2 divides the smaller component; asin uses the sine table
    side0_nxt.sin_br    = (in_req_type == OP_ASIN) ||
                          ((in_req_type == OP_ATAN2) && y_small);
    side0_nxt.num       = ((in_req_type == OP_ATAN2) && y_small) ? my : mx;
  end

  logic        vld0_r;
  logic [31:0] mx_r;
  logic [31:0] my_r;
  itau_side_t  side0_r;

  // ---- stage 1: squares ---------------------------------------------------
  logic        vld1_r;
  logic [63:0] sqx_r;
  logic [63:0] sqy_r;
  itau_side_t  side1_r;

  // ---- stage 2: x*x + y*y, Q32.32 ------------------------------------------
  logic        vld2_r;
  logic [63:0] rad_r;
  itau_side_t  side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld0_r <= acc;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    mx_r    <= mx;
    my_r    <= my;
    side0_r <= side0_nxt;
    sqx_r   <= {32'd0, mx_r} * {32'd0, mx_r};
    sqy_r   <= {32'd0, my_r} * {32'd0, my_r};
    side1_r <= side0_r;
    rad_r   <= sqx_r + sqy_r;
    side2_r <= side1_r;
  end

  // ---- square root ---------------------------------------------------------
  logic        sq_vld;
  logic [31:0] sq_root;
  itau_side_t  sq_side;
  itau_side_t  dv_side_in;

  itau_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld2_r),
    .in_rad   (rad_r),
    .in_side  (side2_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // the root is zero only when both components are zero
  always_comb begin
    dv_side_in           = sq_side;
    dv_side_in.root_zero = (sq_root == 32'd0);
  end

  // ---- ratio divide ----------------------------------------------------------
  logic        dv_vld;
  logic [16:0] dv_quot;
  itau_side_t  dv_side;

  itau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_num   (sq_side.num),
    .in_den   (sq_root),
    .in_side  (dv_side_in),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // ---- L1: ratio select, ROM read ------------------------------------------
  logic               l1_sat_nxt;
  logic               l1_kill_nxt;
  logic [15:0]        l1_e0_nxt;
  logic signed [16:0] l1_d_nxt;
  logic [7:0]         l1_w_nxt;

  always_comb begin
    logic        is_atan;
    logic [15:0] lo;
    logic [8:0]  idx;
    logic [8:0]  idx1;
    logic [15:0] e1;
    is_atan     = dv_side.op == OP_ATAN2;
    lo          = is_atan ? dv_quot[15:0] : dv_side.lo16;
    l1_sat_nxt  = is_atan ? dv_quot[16] : dv_side.pre_sat;
    l1_kill_nxt = (dv_side.op == OP_NONE) || (is_atan && dv_side.root_zero);
    idx         = {1'b0, lo[15:8]};
    idx1        = idx + 9'd1;
    l1_e0_nxt   = dv_side.sin_br ? ASIN_ROM[idx] : ACOS_ROM[idx];
    e1          = dv_side.sin_br ? ASIN_ROM[idx1] : ACOS_ROM[idx1];
    l1_d_nxt    = $signed({1'b0, e1}) - $signed({1'b0, l1_e0_nxt});
    l1_w_nxt    = lo[7:0];
  end

  logic               l1_vld_r;
  logic               l1_sat_r;
  logic               l1_kill_r;
  logic [15:0]        l1_e0_r;
  logic signed [16:0] l1_d_r;
  logic [7:0]         l1_w_r;
  itau_side_t         l1_side_r;

  // ---- L2: interpolation product -------------------------------------------
  logic               l2_vld_r;
  logic               l2_sat_r;
  logic               l2_kill_r;
  logic [15:0]        l2_e0_r;
  logic signed [25:0] l2_prod_r;
  itau_side_t         l2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_vld_r  <= 1'b0;
      l2_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      l1_vld_r  <= dv_vld;
      l2_vld_r  <= l1_vld_r;
      out_valid <= l2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_sat_r  <= l1_sat_nxt;
    l1_kill_r <= l1_kill_nxt;
    l1_e0_r   <= l1_e0_nxt;
    l1_d_r    <= l1_d_nxt;
    l1_w_r    <= l1_w_nxt;
    l1_side_r <= dv_side;
    l2_sat_r  <= l1_sat_r;
    l2_kill_r <= l1_kill_r;
    l2_e0_r   <= l1_e0_r;
    l2_prod_r <= l1_d_r * $signed({1'b0, l1_w_r});
    l2_side_r <= l1_side_r;
  end

  // ---- L3: add, sign and quadrant reflection, all modulo 2^16 -------------
  logic [15:0] angle_nxt;

  always_comb begin
    logic signed [25:0] delta;
    logic [15:0]        a;
    logic               neg_t;
    logic               is_atan;
    logic [15:0]        t;
    delta   = l2_prod_r >>> 8;   // floor toward minus infinity
    a       = l2_e0_r + delta[15:0];
    is_atan = l2_side_r.op == OP_ATAN2;
    neg_t   = (is_atan && l2_side_r.sin_br) ? l2_side_r.neg_y : l2_side_r.neg_x;
    if (l2_side_r.sin_br) begin
      if (l2_sat_r)   t = ANG_QUARTER;
      else if (neg_t) t = 16'd0 - a;
      else            t = a;
    end else begin
      if (l2_sat_r)   t = 16'd0;
      else if (neg_t) t = ANG_HALF - a;
      else            t = a;
    end
    if (is_atan) begin
      if (l2_side_r.sin_br && l2_side_r.neg_x)       t = ANG_HALF - t;
      else if (!l2_side_r.sin_br && l2_side_r.neg_y) t = 16'd0 - t;
    end
    angle_nxt = l2_kill_r ? 16'd0 : t;
  end

  logic [15:0] angle_r;

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign out_angle_out = angle_r;

  // ---- checks ----------------------------------------------------------------
  `ITAU_AST_DLY(a_latency, acc, LAT, out_valid, "accepted word gave no result")
  `ITAU_AST_DLY(a_no_extra, !acc, LAT, !out_valid, "result without an accepted word")
  `ITAU_AST_DLY(a_unused_op, acc && in_req_type == OP_NONE, LAT, out_angle_out == '0, "op 3")
  `ITAU_AST_NXT(a_kill, l2_vld_r && l2_kill_r, out_valid && out_angle_out == '0, "killed word")

endmodule
